/* src/ndbt_pkg.sv */
// shared types and constants for the nv dirty block tracker
package ndbt_pkg;

  localparam int OffW = 15;
  localparam int SigW = 32;
  localparam int IdxW = 6;
  localparam int ActW = 3;

  localparam logic [SigW-1:0] SIG_WORD = 32'h324D_5054;

  typedef logic [OffW-1:0] off_t;
  typedef logic [SigW-1:0] sig_t;
  typedef logic [IdxW-1:0] block_idx_t;
  typedef logic [ActW-1:0] act_t;

  typedef enum logic [ActW-1:0] {
    ACT_WRITE    = 3'd0,
    ACT_CLEAR    = 3'd1,
    ACT_MOVE     = 3'd2,
    ACT_COMMIT   = 3'd3,
    ACT_LOAD_SIG = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_FINISH,
    ST_SCAN,
    ST_STATE_BLK
  } state_e;

endpackage

/* src/ndbt_req_if.sv */
// request channel interface
interface ndbt_req_if;
  import ndbt_pkg::*;

  logic valid;
  logic ready;
  act_t action;
  off_t first_offset;
  off_t second_offset;
  off_t length;
  sig_t signature;

  modport source (
    output valid, action, first_offset, second_offset, length, signature,
    input  ready
  );

  modport sink (
    input  valid, action, first_offset, second_offset, length, signature,
    output ready
  );
endinterface

/* src/ndbt_rsp_if.sv */
// response channel interface
interface ndbt_rsp_if;
  import ndbt_pkg::*;

  logic       valid;
  logic       ready;
  logic       status;
  logic       block_valid;
  block_idx_t block_index;
  logic       last;
  logic       needs_manufacture;

  modport source (
    output valid, status, block_valid, block_index, last, needs_manufacture,
    input  ready
  );

  modport sink (
    input  valid, status, block_valid, block_index, last, needs_manufacture,
    output ready
  );
endinterface

/* src/ndbt_blk_cmp.sv */
// block versus byte range overlap compare unit
module ndbt_blk_cmp #(
  parameter int AW          = 19,
  parameter int BLOCK_BYTES = 512
) (
  input  logic [AW-1:0]     base_i,
  input  ndbt_pkg::off_t    off_i,
  input  ndbt_pkg::off_t    len_i,
  output logic              hit_o
);
  import ndbt_pkg::*;

  logic [AW-1:0] end_w;
  logic [AW-1:0] top_w;

  assign end_w = AW'(off_i) + AW'(len_i);
  assign top_w = base_i + AW'(BLOCK_BYTES);
  assign hit_o = (len_i != '0) && (base_i < end_w) && (top_w > AW'(off_i));

endmodule

/* src/nv_dirty_block_tracker.sv */
// dirty block bitmap tracker for a shadow nv memory
//
// requests arrive on req_i and results leave on rsp_o, both valid/ready
// channels; a transaction moves at a clock edge where valid and ready are high.
// write, clear and move check the byte range and then sweep the blocks one
// per cycle through a single overlap compare unit: write and clear sweep once,
// move twice (source pass, then destination pass).
// a range that fails the bounds check or has zero length skips the sweep.
// commit scans the bitmap one block per cycle, waiting on a stalled receiver
// at each dirty block, which it emits and clears, then the state block if the
// manufacture flag is set; with neither, it gives one result with no block.
// load signature and unused actions give a single result with no block.
// one request is handled at a time; req_i.ready is high only between requests.
// results sit in an output register, so a new request is taken while the last
// result still waits; a stalled receiver halts commit at a dirty block.
// reset clears the bitmap and the manufacture flag and leaves the block idle,
// ready for a request.
module nv_dirty_block_tracker #(
  parameter int BLOCKS      = 32,
  parameter int BLOCK_BYTES = 512
) (
  input logic        clk_i,
  input logic        rst_ni,
  ndbt_req_if.sink   req_i,
  ndbt_rsp_if.source rsp_o
);
  import ndbt_pkg::*;

  localparam int NvBytes = BLOCKS * BLOCK_BYTES;
  localparam int AW      = $clog2(NvBytes + 65536);
  localparam int IW      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  state_e            state_q, state_d;
  logic [BLOCKS-1:0] map_q, map_d;
  logic              flag_q, flag_d;
  logic [IW-1:0]     b_q, b_d;
  logic [AW-1:0]     base_q, base_d;
  logic              move_q, move_d;
  logic              phase_q, phase_d;
  logic              st_q, st_d;
  logic              any_q, any_d;
  off_t              off1_q, off2_q, len_q;

  logic              ovalid_q, ovalid_d;
  logic              ostatus_q, ostatus_d;
  logic              obv_q, obv_d;
  block_idx_t        oidx_q, oidx_d;
  logic              olast_q, olast_d;
  logic              onm_q, onm_d;

  logic              accept;
  logic              out_free;
  logic              last_b;
  logic              fits1, fits2, len_nz;
  logic              hit;
  logic              emit, step;
  logic [BLOCKS-1:0] rest;
  logic              rest_nz;
  off_t              cmp_off;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !ovalid_q || rsp_o.ready;
  assign last_b   = (b_q == IW'(BLOCKS - 1));
  assign len_nz   = (req_i.length != '0);
  assign fits1    = (AW'(req_i.first_offset) + AW'(req_i.length)) <= AW'(NvBytes);
  assign fits2    = (AW'(req_i.second_offset) + AW'(req_i.length)) <= AW'(NvBytes);
  assign cmp_off  = phase_q ? off2_q : off1_q;
  assign emit     = map_q[b_q] && out_free;
  assign step     = !map_q[b_q] || out_free;

  always_comb begin
    rest       = map_q;
    rest[b_q]  = 1'b0;
    rest_nz    = |rest;
  end

  ndbt_blk_cmp #(
    .AW          (AW),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_cmp (
    .base_i (base_q),
    .off_i  (cmp_off),
    .len_i  (len_q),
    .hit_o  (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.action) inside
            ACT_WRITE, ACT_CLEAR: state_d = (fits1 && len_nz) ? ST_MARK : ST_FINISH;
            ACT_MOVE: state_d = (fits1 && fits2 && len_nz) ? ST_MARK : ST_FINISH;
            ACT_COMMIT: state_d = ST_SCAN;
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_MARK: begin
        if (last_b && !(move_q && !phase_q)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (step && last_b) begin
          if (flag_q) begin
            state_d = ST_STATE_BLK;
          end else if (any_q || emit) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_STATE_BLK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    map_d     = map_q;
    flag_d    = flag_q;
    b_d       = b_q;
    base_d    = base_q;
    move_d    = move_q;
    phase_d   = phase_q;
    st_d      = st_q;
    any_d     = any_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    ostatus_d = ostatus_q;
    obv_d     = obv_q;
    oidx_d    = oidx_q;
    olast_d   = olast_q;
    onm_d     = onm_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          b_d     = '0;
          base_d  = '0;
          phase_d = 1'b0;
          any_d   = 1'b0;
          move_d  = (req_i.action == ACT_MOVE);
          unique case (req_i.action) inside
            ACT_WRITE, ACT_CLEAR: st_d = !fits1;
            ACT_MOVE: st_d = !(fits1 && fits2);
            ACT_LOAD_SIG: begin
              st_d = 1'b0;
              if (req_i.signature != SIG_WORD) begin
                flag_d = 1'b1;
              end
            end
            default: st_d = 1'b0;
          endcase
        end
      end
      ST_MARK: begin
        if (hit) begin
          map_d[b_q] = 1'b1;
        end
        if (last_b) begin
          b_d     = '0;
          base_d  = '0;
          phase_d = 1'b1;
        end else begin
          b_d    = b_q + IW'(1);
          base_d = base_q + AW'(BLOCK_BYTES);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = st_q;
          obv_d     = 1'b0;
          oidx_d    = '0;
          olast_d   = 1'b1;
          onm_d     = flag_q;
        end
      end
      ST_SCAN: begin
        if (emit) begin
          ovalid_d   = 1'b1;
          ostatus_d  = 1'b0;
          obv_d      = 1'b1;
          oidx_d     = block_idx_t'(b_q);
          olast_d    = !rest_nz && !flag_q;
          onm_d      = 1'b0;
          map_d[b_q] = 1'b0;
          any_d      = 1'b1;
        end
        if (step) begin
          b_d = last_b ? '0 : b_q + IW'(1);
        end
      end
      ST_STATE_BLK: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = 1'b0;
          obv_d     = 1'b1;
          oidx_d    = block_idx_t'(BLOCKS);
          olast_d   = 1'b1;
          onm_d     = 1'b0;
          flag_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      map_q    <= '0;
      flag_q   <= 1'b0;
      b_q      <= '0;
      base_q   <= '0;
      move_q   <= 1'b0;
      phase_q  <= 1'b0;
      st_q     <= 1'b0;
      any_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      map_q    <= map_d;
      flag_q   <= flag_d;
      b_q      <= b_d;
      base_q   <= base_d;
      move_q   <= move_d;
      phase_q  <= phase_d;
      st_q     <= st_d;
      any_q    <= any_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      off1_q <= req_i.first_offset;
      off2_q <= req_i.second_offset;
      len_q  <= req_i.length;
    end
    ostatus_q <= ostatus_d;
    obv_q     <= obv_d;
    oidx_q    <= oidx_d;
    olast_q   <= olast_d;
    onm_q     <= onm_d;
  end

  assign req_i.ready             = (state_q == ST_IDLE);
  assign rsp_o.valid             = ovalid_q;
  assign rsp_o.status            = ostatus_q;
  assign rsp_o.block_valid       = obv_q;
  assign rsp_o.block_index       = oidx_q;
  assign rsp_o.last              = olast_q;
  assign rsp_o.needs_manufacture = onm_q;

  // a finished commit leaves nothing dirty
  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q) == ST_SCAN) |-> (map_q == '0 && !flag_q))
    else $error("commit left dirty state");

  // the state block is always the final result
  a_state_blk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.block_valid && rsp_o.block_index == block_idx_t'(BLOCKS))
      |-> (rsp_o.last && !rsp_o.needs_manufacture))
    else $error("state block result malformed");

  // a bounds failure carries no block
  a_status_no_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (!rsp_o.block_valid && rsp_o.last))
    else $error("bounds failure with block result");

endmodule

/* dv/nv_dirty_block_tracker_tb.sv */
`timescale 1ns / 100ps
// testbench for the nv dirty block tracker with a bitmap scoreboard
module nv_dirty_block_tracker_tb;
  import ndbt_pkg::*;

  localparam int NBLOCKS      = 32;
  localparam int BLOCK_BYTES  = 512;
  localparam int NV_BYTES     = NBLOCKS * BLOCK_BYTES;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 110;
  localparam int CALM_FIRST   = 120;
  localparam int CALM_LAST    = 136;
  localparam int DRAIN_CYCLES = 2 * NBLOCKS + 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam act_t ACT_SPARE_FIRST = 3'd5;
  localparam act_t ACT_SPARE_MID   = 3'd6;
  localparam act_t ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    act_t action;
    off_t first_offset;
    off_t second_offset;
    off_t length;
    sig_t signature;
  } req_item_t;

  typedef struct packed {
    logic       status;
    logic       block_valid;
    block_idx_t block_index;
    logic       last;
    logic       needs_manufacture;
  } rsp_item_t;

  class dirty_block_scoreboard;
    logic [NBLOCKS-1:0] dirty_map;
    logic               mfg_flag;
    rsp_item_t          expected_q[$];
    int                 failures;
    int                 checked;
    int                 write_backs;
    int                 state_blocks;
    int                 out_of_range;
    int                 per_action[8];

    function new();
      dirty_map = '0;
      mfg_flag  = 1'b0;
    endfunction

    function bit fits(off_t off, off_t len);
      return (int'(off) + int'(len)) <= NV_BYTES;
    endfunction

    function void mark(off_t off, off_t len);
      int lo;
      int hi;
      if (len == '0) return;
      lo = int'(off) / BLOCK_BYTES;
      hi = (int'(off) + int'(len) - 1) / BLOCK_BYTES;
      for (int b = lo; b <= hi && b < NBLOCKS; b++) dirty_map[b] = 1'b1;
    endfunction

    function string show(rsp_item_t r);
      return $sformatf("status=%0d block_valid=%0d block_index=%0d last=%0d needs_mfg=%0d",
                       r.status, r.block_valid, r.block_index, r.last, r.needs_manufacture);
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("mismatch %0d: %s", failures, msg);
    endfunction

    function void note_input(req_item_t rq);
      rsp_item_t batch[$];
      rsp_item_t r;
      bit        bad;
      per_action[rq.action]++;
      r = '{status: 1'b0, block_valid: 1'b0, block_index: '0, last: 1'b1,
            needs_manufacture: 1'b0};
      case (rq.action) inside
        ACT_WRITE, ACT_CLEAR: begin
          bad = !fits(rq.first_offset, rq.length);
          if (!bad) mark(rq.first_offset, rq.length);
          out_of_range += bad;
          r.status = bad;
          batch.push_back(r);
        end
        ACT_MOVE: begin
          bad = !(fits(rq.first_offset, rq.length) && fits(rq.second_offset, rq.length));
          if (!bad) begin
            mark(rq.first_offset, rq.length);
            mark(rq.second_offset, rq.length);
          end
          out_of_range += bad;
          r.status = bad;
          batch.push_back(r);
        end
        ACT_COMMIT: begin
          r.block_valid = 1'b1;
          r.last        = 1'b0;
          for (int b = 0; b < NBLOCKS; b++) begin
            if (dirty_map[b]) begin
              r.block_index = block_idx_t'(b);
              batch.push_back(r);
              dirty_map[b] = 1'b0;
              write_backs++;
            end
          end
          if (mfg_flag) begin
            r.block_index = block_idx_t'(NBLOCKS);
            batch.push_back(r);
            mfg_flag = 1'b0;
            state_blocks++;
          end
          if (batch.size() == 0) begin
            r.block_valid = 1'b0;
            r.block_index = '0;
            r.last        = 1'b1;
            batch.push_back(r);
          end else begin
            batch[batch.size()-1].last = 1'b1;
          end
        end
        ACT_LOAD_SIG: begin
          if (rq.signature != SIG_WORD) mfg_flag = 1'b1;
          batch.push_back(r);
        end
        default: batch.push_back(r);
      endcase
      foreach (batch[k]) begin
        batch[k].needs_manufacture = mfg_flag;
        expected_q.push_back(batch[k]);
      end
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        complain({"unexpected result ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.block_valid !== want.block_valid ||
          got.block_index !== want.block_index || got.last !== want.last ||
          got.needs_manufacture !== want.needs_manufacture)
        complain({"expected ", show(want), " got ", show(got)});
    endfunction

    function void flush_leftovers();
      while (expected_q.size() != 0) complain({"missing result ", show(expected_q.pop_front())});
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_off = 1'b0;
  logic no_idle  = 1'b0;
  int   sent_cnt = 0;
  int   cycles   = 0;

  dirty_block_scoreboard sb = new();

  ndbt_req_if req_if ();
  ndbt_rsp_if rsp_if ();

  nv_dirty_block_tracker #(
    .BLOCKS      (NBLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int        stall_left;
    int        r;
    rsp_item_t got;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status            = rsp_if.status;
        got.block_valid       = rsp_if.block_valid;
        got.block_index       = rsp_if.block_index;
        got.last              = rsp_if.last;
        got.needs_manufacture = rsp_if.needs_manufacture;
        sb.check_result(got);
      end
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_if.ready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(19, 39);
          rsp_if.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    wait (sent_cnt >= HOLD_AT);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic req_item_t mk(act_t a, int o1, int o2, int len, sig_t s);
    req_item_t rq;
    rq.action        = a;
    rq.first_offset  = off_t'(o1);
    rq.second_offset = off_t'(o2);
    rq.length        = off_t'(len);
    rq.signature     = s;
    return rq;
  endfunction

  function automatic req_item_t random_item();
    req_item_t rq;
    int        pick;
    int        len;
    pick = $urandom_range(0, 99);
    rq.signature = $urandom();
    if (pick < 8) begin
      rq.action        = act_t'($urandom());
      rq.first_offset  = off_t'($urandom());
      rq.second_offset = off_t'($urandom());
      rq.length        = off_t'($urandom());
      return rq;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NV_BYTES)
                                      : $urandom_range(0, 3 * BLOCK_BYTES);
    rq.length        = off_t'(len);
    rq.first_offset  = off_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, NV_BYTES)
                                                         : $urandom_range(0, NV_BYTES - len));
    rq.second_offset = off_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, NV_BYTES)
                                                         : $urandom_range(0, NV_BYTES - len));
    if (pick < 33) begin
      rq.action = ACT_WRITE;
    end else if (pick < 45) begin
      rq.action = ACT_CLEAR;
    end else if (pick < 62) begin
      rq.action = ACT_MOVE;
    end else if (pick < 84) begin
      rq.action = ACT_COMMIT;
    end else begin
      rq.action = ACT_LOAD_SIG;
      if ($urandom_range(0, 1) == 1) rq.signature = SIG_WORD;
    end
    return rq;
  endfunction

  task automatic send_item(req_item_t rq);
    int gap;
    int r;
    req_if.valid         <= 1'b1;
    req_if.action        <= rq.action;
    req_if.first_offset  <= rq.first_offset;
    req_if.second_offset <= rq.second_offset;
    req_if.length        <= rq.length;
    req_if.signature     <= rq.signature;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_input(rq);
    sent_cnt++;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (hold_off || no_idle) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
    send_item(mk(ACT_WRITE, 0, 0, 0, '0));
    send_item(mk(ACT_WRITE, NV_BYTES, 0, 0, '0));
    send_item(mk(ACT_CLEAR, NV_BYTES + 1, 0, 0, '0));
    send_item(mk(ACT_WRITE, 0, 0, NV_BYTES, '0));
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
    send_item(mk(ACT_WRITE, BLOCK_BYTES - 1, 0, 2, '0));
    send_item(mk(ACT_CLEAR, NV_BYTES - 1, 0, 1, '0));
    send_item(mk(ACT_WRITE, NV_BYTES - 1, 0, 2, '0));
    send_item(mk(ACT_MOVE, 0, NV_BYTES - BLOCK_BYTES, BLOCK_BYTES, '0));
    send_item(mk(ACT_MOVE, 16000, 0, BLOCK_BYTES, '0));
    send_item(mk(ACT_MOVE, 0, 16000, BLOCK_BYTES, '0));
    send_item(mk(ACT_LOAD_SIG, 0, 0, 0, SIG_WORD));
    send_item(mk(ACT_LOAD_SIG, 0, 0, 0, '0));
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
    send_item(mk(ACT_LOAD_SIG, 0, 0, 0, '1));
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
    send_item(mk(ACT_SPARE_FIRST, 0, 0, 0, '0));
    send_item(mk(ACT_SPARE_MID, 32767, 32767, 32767, '1));
    send_item(mk(ACT_SPARE_LAST, 100, 200, 300, SIG_WORD));
    send_item(mk(ACT_WRITE, 32767, 0, 32767, '0));
    send_item(mk(ACT_MOVE, 32767, 32767, 32767, '0));
    send_item(mk(ACT_CLEAR, BLOCK_BYTES + 1, 0, 2 * BLOCK_BYTES, '0));
    send_item(mk(ACT_COMMIT, 0, 0, 0, '0));
  endtask

  task automatic run_random();
    int        counted;
    req_item_t rq;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_idle <= (sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST);
      if (sent_cnt == PAUSE_AT) begin
        req_if.valid <= 1'b0;
        wait_all_results();
      end
      rq = random_item();
      send_item(rq);
      if (rq.action <= ACT_LOAD_SIG) counted++;
    end
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.action        = '0;
    req_if.first_offset  = '0;
    req_if.second_offset = '0;
    req_if.length        = '0;
    req_if.signature     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni  <= 1'b1;
    no_idle <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    req_if.valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.flush_leftovers();
    $display("covered %0d transactions: write %0d, clear %0d, move %0d, commit %0d,",
             sent_cnt, sb.per_action[ACT_WRITE], sb.per_action[ACT_CLEAR],
             sb.per_action[ACT_MOVE], sb.per_action[ACT_COMMIT]);
    $display("  load %0d, unused %0d; %0d results checked, %0d block write-backs,",
             sb.per_action[ACT_LOAD_SIG],
             sb.per_action[ACT_SPARE_FIRST] + sb.per_action[ACT_SPARE_MID] +
             sb.per_action[ACT_SPARE_LAST],
             sb.checked, sb.write_backs);
    $display("  %0d state block, %0d out of range, %0d errors",
             sb.state_blocks, sb.out_of_range, sb.failures);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
